>>> design/rmt_pkg.sv
// Shared constants and codes for the range minimum / argmin tree.
`default_nettype none

package rmt_pkg;

    localparam int LEAVES_DEFAULT = 1024;
    localparam int VALUE_BITS     = 16;
    localparam int POS_BITS       = 10;
    localparam int RANGE_BITS     = 11;

    localparam logic [VALUE_BITS-1:0] EMPTY_RESET = 16'hFFFF;

    // operation codes on the func field
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> design/rmt_if.sv
// Valid/ready channel interfaces for the input and result items.
`default_nettype none

interface rmt_in_if import rmt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [POS_BITS-1:0]   position;
    logic [VALUE_BITS-1:0] new_value;
    logic [RANGE_BITS-1:0] range_start;
    logic [RANGE_BITS-1:0] range_end;

    modport source (
        output valid, func, position, new_value, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, func, position, new_value, range_start, range_end,
        output ready
    );
endinterface

interface rmt_out_if import rmt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] min_value;
    logic [POS_BITS-1:0]   min_index;
    logic                  found;

    modport source (
        output valid, min_value, min_index, found,
        input  ready
    );
    modport sink (
        input  valid, min_value, min_index, found,
        output ready
    );
endinterface

`default_nettype wire

>>> design/range_min_argmin_tree_core.sv
// Segment tree with range minimum and leftmost argmin, one node memory.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  i_in     | in  | valid/ready   | func, position, new_value, range_start, range_end
//  o_out    | out | valid/ready   | min_value, min_index, found (queries only)
//  i_cfg_*  | in  | wr_en         | empty_value
//
// Node store is one memory, one read and one write per cycle; the sequencer drives it.
// Update: one sibling read per level.
// Query: a left-bound read, a right-bound read and a shift step per tree level walked.
// After reset a clearing pass fills the store; no item is taken meanwhile, config
// writes are. A waiting result holds only the final step.
`default_nettype none

module range_min_argmin_tree_core import rmt_pkg::*; #(
    parameter int LEAVES = LEAVES_DEFAULT
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    rmt_in_if.sink                 i_in,
    rmt_out_if.source              o_out,
    input  wire                    i_cfg_wr_en,
    input  wire [VALUE_BITS-1:0]   i_cfg_wr_data
);

    localparam int LVL   = $clog2(LEAVES);
    localparam int SLOTS = 1 << LVL;
    localparam int AW    = LVL + 1;              // node address, nodes 1..2*SLOTS-1
    localparam int IW    = LVL + 2;              // leaf cursor, up to 2*SLOTS
    localparam int XW    = (IW > RANGE_BITS) ? IW : RANGE_BITS;
    localparam int NODES = 2 * SLOTS;

    typedef struct packed {
        logic [VALUE_BITS-1:0] val;
        logic [LVL-1:0]        pos;
    } t_node;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] val;
        logic [LVL-1:0]        pos;
    } t_acc;

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_U_RD  = 8'b0000_0100,
        S_U_WR  = 8'b0000_1000,
        S_Q_L   = 8'b0001_0000,
        S_Q_R   = 8'b0010_0000,
        S_Q_SH  = 8'b0100_0000,
        S_Q_FIN = 8'b1000_0000
    } t_state;

    // left operand wins ties
    function automatic t_acc f_pick(input t_acc a, input t_acc b);
        t_acc res;
        if (a.found && (!b.found || a.val <= b.val)) begin
            res = a;
        end else begin
            res = b;
        end
        return res;
    endfunction

    function automatic t_acc f_acc(input t_node n);
        t_acc res;
        res.found = 1'b1;
        res.val   = n.val;
        res.pos   = n.pos;
        return res;
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_clr_node, n_clr_node;
    logic [LVL-1:0]        r_clr_pos, n_clr_pos;
    logic [LVL:0]          r_clr_stride, n_clr_stride;
    logic [VALUE_BITS-1:0] r_empty;
    logic [AW-1:0]         r_node, n_node;
    t_node                 r_cur, n_cur;
    logic [IW-1:0]         r_l, n_l;
    logic [IW-1:0]         r_r, n_r;
    logic                  r_pend_l, n_pend_l;
    logic                  r_pend_r, n_pend_r;
    t_acc                  r_acc_l, n_acc_l;
    t_acc                  r_acc_r, n_acc_r;
    logic                  r_ov, n_ov;
    logic [VALUE_BITS-1:0] r_out_val, n_out_val;
    logic [POS_BITS-1:0]   r_out_idx, n_out_idx;
    logic                  r_out_found, n_out_found;

    t_node                 r_mem [0:NODES-1];
    t_node                 r_rd;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    t_node                 mem_wd;
    logic [AW-1:0]         mem_ra;

    logic [XW-1:0]         pos_x, a_x, b_x, b_c, slots_x;
    t_node                 leaf, left, right, par;
    t_acc                  cmp_a, cmp_b, cmp_res;
    t_acc                  fin;
    logic [IW-1:0]         dec_r;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.min_value = r_out_val;
    assign o_out.min_index = r_out_idx;
    assign o_out.found     = r_out_found;

    assign slots_x = XW'(SLOTS);
    assign pos_x   = XW'(i_in.position);
    assign a_x     = XW'(i_in.range_start);
    assign b_x     = XW'(i_in.range_end);
    assign b_c     = (b_x > slots_x) ? slots_x : b_x;
    assign dec_r   = r_r - IW'(1);
    assign fin     = cmp_res;

    always_comb begin
        leaf.val = i_in.new_value;
        leaf.pos = LVL'(pos_x);
        if (r_node[0]) begin
            left  = r_rd;
            right = r_cur;
        end else begin
            left  = r_cur;
            right = r_rd;
        end
        // one compare unit, operands steered by the sequencer state
        case (r_state)
            S_U_WR: begin
                cmp_a = f_acc(left);
                cmp_b = f_acc(right);
            end
            S_Q_R: begin
                cmp_a = r_acc_l;
                cmp_b = f_acc(r_rd);
            end
            S_Q_SH: begin
                cmp_a = f_acc(r_rd);
                cmp_b = r_acc_r;
            end
            default: begin
                cmp_a = r_acc_l;
                cmp_b = r_acc_r;
            end
        endcase
        cmp_res = f_pick(cmp_a, cmp_b);
        par.val = cmp_res.val;
        par.pos = cmp_res.pos;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_node   = r_clr_node;
        n_clr_pos    = r_clr_pos;
        n_clr_stride = r_clr_stride;
        n_node       = r_node;
        n_cur        = r_cur;
        n_l          = r_l;
        n_r          = r_r;
        n_pend_l     = r_pend_l;
        n_pend_r     = r_pend_r;
        n_acc_l      = r_acc_l;
        n_acc_r      = r_acc_r;
        n_ov         = r_ov & ~o_out.ready;
        n_out_val    = r_out_val;
        n_out_idx    = r_out_idx;
        n_out_found  = r_out_found;
        mem_we       = 1'b0;
        mem_wa       = r_node;
        mem_wd       = r_cur;
        mem_ra       = r_node ^ AW'(1);

        case (r_state)
            S_CLR: begin
                mem_we     = 1'b1;
                mem_wa     = r_clr_node;
                mem_wd.val = EMPTY_RESET;
                mem_wd.pos = r_clr_pos;
                n_clr_node = r_clr_node + AW'(1);
                // next node opens a new level: leftmost leaf restarts at zero
                if ((r_clr_node & (r_clr_node + AW'(1))) == '0) begin
                    n_clr_pos    = '0;
                    n_clr_stride = r_clr_stride >> 1;
                end else begin
                    n_clr_pos = r_clr_pos + r_clr_stride[LVL-1:0];
                end
                if (&r_clr_node) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.func == FUNC_WRITE) begin
                        if (pos_x < slots_x) begin
                            mem_we  = 1'b1;
                            mem_wa  = AW'(SLOTS) + AW'(pos_x);
                            mem_wd  = leaf;
                            n_node  = AW'(SLOTS) + AW'(pos_x);
                            n_cur   = leaf;
                            n_state = S_U_RD;
                        end
                    end else begin
                        n_acc_l.found = 1'b0;
                        n_acc_r.found = 1'b0;
                        if (a_x < b_c) begin
                            n_l = IW'(a_x) + IW'(SLOTS);
                            n_r = IW'(b_c) + IW'(SLOTS);
                        end else begin
                            n_l = '0;
                            n_r = '0;
                        end
                        n_state = S_Q_L;
                    end
                end
            end
            S_U_RD: begin
                mem_ra  = r_node ^ AW'(1);
                n_state = S_U_WR;
            end
            S_U_WR: begin
                mem_we = 1'b1;
                mem_wa = r_node >> 1;
                mem_wd = par;
                n_cur  = par;
                n_node = r_node >> 1;
                if ((r_node >> 1) == AW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_U_RD;
                end
            end
            S_Q_L: begin
                mem_ra = r_l[AW-1:0];
                if (r_l < r_r) begin
                    n_pend_l = r_l[0];
                    if (r_l[0]) begin
                        n_l = r_l + IW'(1);
                    end
                    n_state = S_Q_R;
                end else begin
                    n_state = S_Q_FIN;
                end
            end
            S_Q_R: begin
                if (r_pend_l) begin
                    n_acc_l = cmp_res;
                end
                mem_ra   = dec_r[AW-1:0];
                n_pend_r = r_r[0];
                if (r_r[0]) begin
                    n_r = dec_r;
                end
                n_state = S_Q_SH;
            end
            S_Q_SH: begin
                if (r_pend_r) begin
                    n_acc_r = cmp_res;
                end
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = S_Q_L;
            end
            S_Q_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_ov        = 1'b1;
                    n_out_found = fin.found;
                    n_out_val   = fin.found ? fin.val : r_empty;
                    n_out_idx   = fin.found ? POS_BITS'(fin.pos) : '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_node   <= AW'(1);
            r_clr_pos    <= '0;
            r_clr_stride <= (LVL+1)'(SLOTS);
            r_ov         <= 1'b0;
            r_empty      <= EMPTY_RESET;
        end else begin
            r_state      <= n_state;
            r_clr_node   <= n_clr_node;
            r_clr_pos    <= n_clr_pos;
            r_clr_stride <= n_clr_stride;
            r_ov         <= n_ov;
            if (i_cfg_wr_en) begin
                r_empty <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_cur       <= n_cur;
        r_l         <= n_l;
        r_r         <= n_r;
        r_pend_l    <= n_pend_l;
        r_pend_r    <= n_pend_r;
        r_acc_l     <= n_acc_l;
        r_acc_r     <= n_acc_r;
        r_out_val   <= n_out_val;
        r_out_idx   <= n_out_idx;
        r_out_found <= n_out_found;
    end

    // node store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

endmodule

`default_nettype wire

>>> verif/rmt_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the range minimum tree: mirrors the leaf values, predicts query answers, compares.
module rmt_checker import rmt_pkg::*; #(
    parameter int SLOTS = LEAVES_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rmt_in_if                     i_in,
    rmt_out_if                    i_out,
    input  logic                  i_cfg_wr_en,
    input  logic [VALUE_BITS-1:0] i_cfg_wr_data,
    output int                    o_mismatches,
    output int                    o_answers_due
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] min_value;
        logic [POS_BITS-1:0]   min_index;
        logic                  found;
    } t_answer;

    logic [VALUE_BITS-1:0] leaf_value [SLOTS];
    logic [VALUE_BITS-1:0] empty_value;
    t_answer               answers_due [$];
    int                    mismatch_count = 0;

    // Leftmost minimum over [lo, hi), hi clipped to the slot count.
    function automatic t_answer range_minimum(input logic [RANGE_BITS-1:0] lo_in,
                                              input logic [RANGE_BITS-1:0] hi_in);
        int      lo;
        int      hi;
        int      k;
        t_answer ans;
        lo = int'(lo_in);
        hi = int'(hi_in);
        if (hi > SLOTS) begin
            hi = SLOTS;
        end
        ans.min_value = empty_value;
        ans.min_index = '0;
        ans.found     = 1'b0;
        for (k = lo; k < hi; k++) begin
            if (!ans.found || leaf_value[k] < ans.min_value) begin
                ans.min_value = leaf_value[k];
                ans.min_index = k[POS_BITS-1:0];
                ans.found     = 1'b1;
            end
        end
        return ans;
    endfunction

    task automatic flag_error(input string what, input t_answer want, input t_answer got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display({"%0t: %s: expected value=%h index=%0d found=%0b, ",
                      "got value=%h index=%0d found=%0b"},
                     $realtime, what, want.min_value, want.min_index, want.found,
                     got.min_value, got.min_index, got.found);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            foreach (leaf_value[k]) begin
                leaf_value[k] = EMPTY_RESET;
            end
            empty_value = EMPTY_RESET;
            answers_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                empty_value = i_cfg_wr_data;
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.func == FUNC_WRITE) begin
                    if (i_in.position < SLOTS) begin
                        leaf_value[i_in.position] = i_in.new_value;
                    end
                end else begin
                    answers_due.insert(answers_due.size(),
                                       range_minimum(i_in.range_start, i_in.range_end));
                end
            end
            if (i_out.valid && i_out.ready) begin
                got.min_value = i_out.min_value;
                got.min_index = i_out.min_index;
                got.found     = i_out.found;
                if (answers_due.size() == 0) begin
                    flag_error("result with no query outstanding", '0, got);
                end else begin
                    want = answers_due.pop_front();
                    if (got.min_value !== want.min_value || got.min_index !== want.min_index
                            || got.found !== want.found) begin
                        flag_error("query result mismatch", want, got);
                    end
                end
            end
        end
        o_answers_due <= answers_due.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the range minimum tree: clock, reset, stimulus and verdict.
module tb_top;
    import rmt_pkg::*;

    localparam int SLOTS            = LEAVES_DEFAULT;
    localparam int TAIL_CYCLES      = 64;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 380;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [VALUE_BITS-1:0] cfg_wr_data = '0;
    logic                  no_idle     = 1'b0;
    logic [VALUE_BITS-1:0] cur_empty   = EMPTY_RESET;
    int                    window_base = 0;
    int                    mismatches;
    int                    answers_due;

    rmt_in_if  in_ch ();
    rmt_out_if out_ch ();

    range_min_argmin_tree_core #(.LEAVES(SLOTS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    rmt_checker #(.SLOTS(SLOTS)) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_mismatches  (mismatches),
        .o_answers_due (answers_due)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input logic func, input logic [POS_BITS-1:0] pos,
                             input logic [VALUE_BITS-1:0] val,
                             input logic [RANGE_BITS-1:0] lo, input logic [RANGE_BITS-1:0] hi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.func        <= func;
        in_ch.position    <= pos;
        in_ch.new_value   <= val;
        in_ch.range_start <= lo;
        in_ch.range_end   <= hi;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // unused fields carry noise
    task automatic send_write(input int pos, input int val);
        send_item(FUNC_WRITE, pos[POS_BITS-1:0], val[VALUE_BITS-1:0],
                  RANGE_BITS'($urandom_range(0, 2047)), RANGE_BITS'($urandom_range(0, 2047)));
    endtask

    task automatic send_query(input int lo, input int hi);
        send_item(FUNC_QUERY, POS_BITS'($urandom_range(0, SLOTS - 1)),
                  VALUE_BITS'($urandom_range(0, 65535)),
                  lo[RANGE_BITS-1:0], hi[RANGE_BITS-1:0]);
    endtask

    // Drain all answers, let a trailing update finish, then change the empty value.
    task automatic write_empty_value(input logic [VALUE_BITS-1:0] val);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (answers_due != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        cur_empty   <= val;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_item();
        int pick;
        int lo;
        int hi;
        int pos;
        int val;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            case ($urandom_range(0, 3))
                0:       val = $urandom_range(0, 3);     // ties
                1:       val = int'(cur_empty);
                default: val = $urandom_range(0, 65535);
            endcase
            pos = $urandom_range(0, 1) ? window_base + $urandom_range(0, 63)
                                       : $urandom_range(0, SLOTS - 1);
            send_write(pos, val);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // empty or inverted range, start may lie past the slots
                lo = $urandom_range(0, 2047);
                hi = $urandom_range(0, lo);
            end else if (pick < 20) begin
                lo = $urandom_range(0, SLOTS - 1);
                hi = $urandom_range(SLOTS, 2047);
            end else if (pick < 25) begin
                lo = 0;
                hi = SLOTS;
            end else if (pick < 70) begin
                lo = window_base + $urandom_range(0, 63);
                hi = lo + $urandom_range(1, 64);
            end else begin
                lo = $urandom_range(0, SLOTS - 1);
                hi = $urandom_range(lo + 1, SLOTS);
            end
            send_query(lo, hi);
        end
    endtask

    // result side: stall drawn per item
    initial begin : drain
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall == 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                do @(posedge i_clk); while (!out_ch.valid);
                repeat (stall - 1) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    initial begin : stimulus
        logic [VALUE_BITS-1:0] settings [PHASES];
        int                    ph;
        int                    n;
        settings[0] = 16'h0000;
        settings[1] = VALUE_BITS'($urandom_range(1, 65534));
        settings[2] = 16'hFFFF;
        settings[3] = VALUE_BITS'($urandom_range(1, 65534));
        settings[4] = 16'h8000;

        in_ch.valid       <= 1'b0;
        in_ch.func        <= FUNC_WRITE;
        in_ch.position    <= '0;
        in_ch.new_value   <= '0;
        in_ch.range_start <= '0;
        in_ch.range_end   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // untouched store: all slots equal the empty value, still found
        send_query(0, SLOTS);
        send_query(5, 5);
        send_query(10, 3);
        send_query(SLOTS, SLOTS);
        send_query(SLOTS - 1, SLOTS);
        send_query(0, 2047);
        send_query(2047, 2047);
        send_write(SLOTS - 1, 0);
        send_write(0, 0);
        send_query(0, SLOTS);            // tie, left wins
        send_write(512, 5);
        send_query(1, SLOTS - 1);
        send_query(SLOTS - 1, SLOTS);
        send_write(700, 5);
        send_query(513, SLOTS);
        send_query(513, SLOTS - 1);
        send_query(0, 1);
        send_write(0, 16'hFFFF);
        send_query(0, SLOTS);
        send_write(SLOTS - 1, 16'hFFFF);
        send_query(0, 2047);             // tie between 512 and 700
        send_write(10'h2AA, 16'h5555);
        send_write(10'h155, 16'hAAAA);
        send_query(10'h155, 10'h2AB);

        for (ph = 0; ph < PHASES; ph++) begin
            write_empty_value(settings[ph]);
            window_base = $urandom_range(0, SLOTS - 64);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 64 == 0) begin
                    no_idle <= ($urandom_range(0, 3) == 0);
                end
                send_random_item();
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (answers_due != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && answers_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
